// File: hw/rtl/hsae_pkg.sv
// Shared types, constants and table functions of the Hall sector angle estimator.
package hsae_pkg;

    localparam int SECTORS = 6;

    localparam logic signed [15:0] Q15_15DEG = 16'sd2730;
    localparam logic signed [15:0] Q15_30DEG = 16'sd5460;
    localparam logic [15:0] DECAY_NUM = 16'd10922;
    localparam logic [22:0] STEP_NUM = 23'd4096000;
    localparam logic [15:0] MIN_PERIOD = 16'd20;
    localparam logic [14:0] HALF_SPD_TH = 15'd500;
    localparam logic [14:0] FULL_SPD_TH = 15'd800;
    localparam logic [18:0] ROUND_HALF = 19'd500000;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [15:0] SAT_Q15 = 16'd32767;
    localparam logic [15:0] PERIOD_RST = 16'd10000;
    localparam logic [18:0] SUM_RST = 19'd60000;

    // centre of sector 1 with reset trims, and its +-15 degree window
    localparam logic signed [15:0] ANGLE_RST = -16'sd16384;
    localparam logic signed [15:0] WIN_LO_RST = -16'sd19114;
    localparam logic signed [15:0] WIN_HI_RST = -16'sd13654;

    // divider geometry
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 20;

    // configuration register indexes
    localparam logic [2:0] CFG_REVERSE_DIR = 3'd0;
    localparam logic [2:0] CFG_CW_SHIFT = 3'd1;
    localparam logic [2:0] CFG_CCW_SHIFT = 3'd2;
    localparam logic [2:0] CFG_ANGLE_OFFSET = 3'd3;
    localparam logic [2:0] CFG_SPEED_GAIN = 3'd4;
    localparam logic [2:0] CFG_PWM_FREQ = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_ADV,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_STALE,
        OP_SPEED,
        OP_STEP,
        OP_SECT,
        OP_CYC,
        OP_DECAY
    } op_t;

    function automatic logic [2:0] next_code(input logic [2:0] c);
        logic [2:0] r;
        unique case (c)
            3'd1: r = 3'd3;
            3'd2: r = 3'd6;
            3'd3: r = 3'd2;
            3'd4: r = 3'd5;
            3'd5: r = 3'd1;
            3'd6: r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] prev_code(input logic [2:0] c);
        logic [2:0] r;
        unique case (c)
            3'd1: r = 3'd5;
            3'd2: r = 3'd3;
            3'd3: r = 3'd1;
            3'd4: r = 3'd6;
            3'd5: r = 3'd4;
            3'd6: r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] cw_base(input logic [2:0] c);
        logic signed [15:0] r;
        unique case (c)
            3'd1: r = -16'sd21844;
            3'd3: r = -16'sd10922;
            3'd4: r = 16'sd21844;
            3'd5: r = 16'sd32767;
            3'd6: r = 16'sd10922;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] ccw_base(input logic [2:0] c);
        logic signed [15:0] r;
        unique case (c)
            3'd1: r = 16'sd32767;
            3'd2: r = 16'sd10922;
            3'd3: r = 16'sd21844;
            3'd4: r = -16'sd10922;
            3'd5: r = -16'sd21844;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    // sector centre, wrapped to 16 bits
    function automatic logic signed [15:0] centre_of(
        input logic [2:0] c,
        input logic rev,
        input logic signed [15:0] cw_sh,
        input logic signed [15:0] ccw_sh,
        input logic signed [15:0] offs
    );
        logic signed [15:0] r;
        if (rev)
        begin
            r = ccw_base(c) + Q15_30DEG + ccw_sh + offs;
        end
        else
        begin
            r = cw_base(c) + Q15_30DEG + cw_sh + offs;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/hsae_if.sv
// Channel interfaces: Hall input word and estimate output word.
interface hsae_in_if;
    logic valid;
    logic ready;
    logic [2:0] hall_code;
    logic [15:0] edge_period;

    modport source (output valid, output hall_code, output edge_period, input ready);
    modport sink (input valid, input hall_code, input edge_period, output ready);
endinterface

interface hsae_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] rotor_angle;
    logic signed [15:0] angle_step;
    logic signed [15:0] speed_raw;
    logic signed [15:0] speed_filtered;
    logic signed [1:0] edge_direction;
    logic locked;
    logic hall_fault;

    modport source (
        output valid, output rotor_angle, output angle_step, output speed_raw,
        output speed_filtered, output edge_direction, output locked,
        output hall_fault, input ready
    );
    modport sink (
        input valid, input rotor_angle, input angle_step, input speed_raw,
        input speed_filtered, input edge_direction, input locked,
        input hall_fault, output ready
    );
endinterface

// File: hw/rtl/hall_sector_angle_estimator.sv
// Top level: Hall sector angle estimator with a shared serial divider.
//  channel   dir  kind           payload
//  hall_in   in   valid/ready    hall_code, edge_period
//  est_out   out  valid/ready    rotor_angle .. hall_fault
//  cfg       in   write only     cfg_we, cfg_index, cfg_wdata
// One word at a time. A word with no edge needs no division, or one when the
// step decays. An edge word runs up to five divisions in the serial divider,
// three when the predicted step is zero. Reset loads the six-period ring and
// sector 1 centre at once. A stalled output holds the next word in ST_EMIT.
module hall_sector_angle_estimator #(
    parameter int TIMEOUT_CYCLES = 2500
) (
    input  logic        clk,
    input  logic        rst_n,
    hsae_in_if.sink     hall_in,
    hsae_out_if.source  est_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata
);
    import hsae_pkg::*;

    localparam logic [15:0] TIMEOUT_W = 16'(TIMEOUT_CYCLES);

    // configuration
    logic               rev_reg;
    logic signed [15:0] cw_reg, ccw_reg, offs_reg;
    logic [30:0]        gain_reg;
    logic [16:0]        pwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg <= 1'b0;
            cw_reg <= 16'sd0;
            ccw_reg <= -16'sd1200;
            offs_reg <= 16'sd0;
            gain_reg <= '0;
            pwm_reg <= 17'd16000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REVERSE_DIR: rev_reg <= cfg_wdata[0];
                CFG_CW_SHIFT: cw_reg <= cfg_wdata[15:0];
                CFG_CCW_SHIFT: ccw_reg <= cfg_wdata[15:0];
                CFG_ANGLE_OFFSET: offs_reg <= cfg_wdata[15:0];
                CFG_SPEED_GAIN: gain_reg <= cfg_wdata;
                CFG_PWM_FREQ: pwm_reg <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // estimator state
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [2:0]         code_reg, code_next;
    logic [15:0]        period_reg, period_next;
    logic               fault_reg, fault_next;
    logic [2:0]         prev_reg, prev_next;
    logic [15:0]        ring_reg [SECTORS];
    logic [15:0]        ring_next [SECTORS];
    logic [2:0]         idx_reg, idx_next;
    logic [18:0]        sum_reg, sum_next;
    logic [15:0]        spd_reg, spd_next;
    logic [15:0]        avg_reg, avg_next;
    logic [15:0]        pred_reg, pred_next;
    logic [15:0]        target_reg, target_next;
    logic [15:0]        idle_reg, idle_next;
    logic [15:0]        since_reg, since_next;
    logic signed [15:0] angle_reg, angle_next;
    logic signed [15:0] lo_reg, lo_next;
    logic signed [15:0] hi_reg, hi_next;
    logic signed [1:0]  dir_reg, dir_next;
    logic               lock_reg, lock_next;
    logic signed [15:0] step_reg, step_next;
    logic [DIV_NW-1:0]  mul_reg, mul_next;
    logic               ovalid_reg, ovalid_next;
    logic signed [15:0] o_angle_reg, o_step_reg, o_spd_reg, o_avg_reg;
    logic signed [1:0]  o_dir_reg;
    logic               o_lock_reg, o_fault_reg;
    logic               load_out;

    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DIV_DW-1:0] div_den;

    hsae_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo)
    );

    // scratch
    logic               fault_in, edge_in;
    logic [15:0]        idle_inc, since_inc;
    logic [18:0]        stale;
    logic [15:0]        per_c;
    logic [2:0]         idx_n;
    logic [18:0]        sum_n;
    logic [15:0]        sat_q;
    logic [17:0]        avg3;
    logic signed [15:0] s, a, ctr, w;
    logic               in_win, half;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        code_next = code_reg;
        period_next = period_reg;
        fault_next = fault_reg;
        prev_next = prev_reg;
        ring_next = ring_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        spd_next = spd_reg;
        avg_next = avg_reg;
        pred_next = pred_reg;
        target_next = target_reg;
        idle_next = idle_reg;
        since_next = since_reg;
        angle_next = angle_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        dir_next = dir_reg;
        lock_next = lock_reg;
        step_next = step_reg;
        mul_next = mul_reg;
        ovalid_next = ovalid_reg && !est_out.ready;
        load_out = 1'b0;
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;

        fault_in = (hall_in.hall_code == 3'd0) || (hall_in.hall_code == 3'd7);
        edge_in = !fault_in && (hall_in.hall_code != prev_reg);
        idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
        since_inc = (since_reg == 16'hFFFF) ? since_reg : since_reg + 16'd1;
        stale = {div_quo[17:0], 1'b0};
        per_c = period_reg;
        idx_n = (idx_reg == 3'(SECTORS - 1)) ? 3'd0 : idx_reg + 3'd1;
        sum_n = '0;
        sat_q = (div_quo > DIV_NW'(SAT_Q15)) ? SAT_Q15 : div_quo[15:0];
        avg3 = 18'(avg_reg) * 18'd3 + 18'(sat_q);
        s = rev_reg ? -step_reg : step_reg;
        a = angle_reg + s;
        if (lo_reg <= hi_reg)
        begin
            in_win = (a >= lo_reg) && (a <= hi_reg);
        end
        else
        begin
            in_win = (a >= lo_reg) || (a <= hi_reg);
        end
        ctr = centre_of(code_reg, rev_reg, cw_reg, ccw_reg, offs_reg);
        half = ((spd_reg[14:0] < HALF_SPD_TH) || (dir_reg == 2'sd0))
            && !(spd_reg[14:0] >= FULL_SPD_TH);
        w = half ? Q15_15DEG : Q15_30DEG;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (hall_in.valid)
                begin
                    code_next = hall_in.hall_code;
                    fault_next = fault_in;
                    period_next = (hall_in.edge_period < MIN_PERIOD) ? MIN_PERIOD
                                                                     : hall_in.edge_period;
                    if (edge_in)
                    begin
                        if (hall_in.hall_code == next_code(prev_reg))
                        begin
                            dir_next = 2'sd1;
                        end
                        else if (hall_in.hall_code == prev_code(prev_reg))
                        begin
                            dir_next = -2'sd1;
                        end
                        else
                        begin
                            dir_next = 2'sd0;
                        end
                        idle_next = '0;
                        since_next = '0;
                        op_next = OP_STALE;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                        since_next = since_inc;
                        if (idle_inc >= TIMEOUT_W)
                        begin
                            spd_next = '0;
                            avg_next = '0;
                            pred_next = '0;
                            step_next = '0;
                            lock_next = 1'b0;
                            angle_next = centre_of(prev_reg, rev_reg, cw_reg, ccw_reg,
                                                   offs_reg);
                            lo_next = angle_next - Q15_15DEG;
                            hi_next = angle_next + Q15_15DEG;
                            state_next = ST_EMIT;
                        end
                        else if (target_reg != 16'd0 && since_inc > target_reg)
                        begin
                            op_next = OP_DECAY;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            step_next = pred_reg;
                            state_next = ST_ADV;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                div_start = 1'b1;
                unique case (op_reg)
                    OP_STALE: begin div_num = DIV_NW'(sum_reg); div_den = DIV_DW'(SECTORS); end
                    OP_SPEED: begin div_num = DIV_NW'(gain_reg); div_den = DIV_DW'(sum_reg); end
                    OP_STEP: begin div_num = DIV_NW'(STEP_NUM); div_den = DIV_DW'(sum_reg); end
                    OP_SECT: begin div_num = DIV_NW'(sum_reg); div_den = DIV_DW'(SECTORS); end
                    OP_CYC: begin div_num = mul_reg; div_den = US_PER_S; end
                    OP_DECAY: begin div_num = DIV_NW'(DECAY_NUM); div_den = DIV_DW'(since_reg); end
                    default: ;
                endcase
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    unique case (op_reg)
                        OP_STALE:
                        begin
                            if (stale != '0 && 19'(period_reg) > stale)
                            begin
                                per_c = stale[15:0];
                            end
                            sum_n = sum_reg - 19'(ring_reg[idx_n]) + 19'(per_c);
                            ring_next[idx_n] = per_c;
                            idx_next = idx_n;
                            sum_next = sum_n;
                            op_next = OP_SPEED;
                            state_next = ST_LOAD;
                        end
                        OP_SPEED:
                        begin
                            spd_next = sat_q;
                            avg_next = (avg_reg == '0) ? sat_q : avg3[17:2];
                            op_next = OP_STEP;
                            state_next = ST_LOAD;
                        end
                        OP_STEP:
                        begin
                            pred_next = sat_q;
                            if (sat_q == '0)
                            begin
                                target_next = TIMEOUT_W;
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                op_next = OP_SECT;
                                state_next = ST_LOAD;
                            end
                        end
                        OP_SECT:
                        begin
                            mul_next = DIV_NW'(div_quo[16:0]) * DIV_NW'(pwm_reg)
                                + DIV_NW'(ROUND_HALF);
                            op_next = OP_CYC;
                            state_next = ST_LOAD;
                        end
                        OP_CYC:
                        begin
                            if (div_quo == '0)
                            begin
                                target_next = 16'd1;
                            end
                            else if (div_quo > DIV_NW'(16'hFFFF))
                            begin
                                target_next = 16'hFFFF;
                            end
                            else
                            begin
                                target_next = div_quo[15:0];
                            end
                            state_next = ST_FIN;
                        end
                        OP_DECAY:
                        begin
                            step_next = div_quo[15:0];
                            state_next = ST_ADV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADV:
            begin
                angle_next = in_win ? a : (s[15] ? lo_reg : hi_reg);
                step_next = s;
                state_next = ST_EMIT;
            end
            ST_FIN:
            begin
                angle_next = ctr;
                lo_next = ctr - w;
                hi_next = ctr + w;
                lock_next = (dir_reg != 2'sd0);
                prev_next = code_reg;
                step_next = pred_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || est_out.ready)
                begin
                    load_out = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_STALE;
            prev_reg <= 3'd1;
            for (int i = 0; i < SECTORS; i++)
            begin
                ring_reg[i] <= PERIOD_RST;
            end
            idx_reg <= '0;
            sum_reg <= SUM_RST;
            spd_reg <= '0;
            avg_reg <= '0;
            pred_reg <= '0;
            target_reg <= TIMEOUT_W;
            idle_reg <= '0;
            since_reg <= '0;
            angle_reg <= ANGLE_RST;
            lo_reg <= WIN_LO_RST;
            hi_reg <= WIN_HI_RST;
            dir_reg <= 2'sd0;
            lock_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            prev_reg <= prev_next;
            ring_reg <= ring_next;
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            spd_reg <= spd_next;
            avg_reg <= avg_next;
            pred_reg <= pred_next;
            target_reg <= target_next;
            idle_reg <= idle_next;
            since_reg <= since_next;
            angle_reg <= angle_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            dir_reg <= dir_next;
            lock_reg <= lock_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        period_reg <= period_next;
        fault_reg <= fault_next;
        step_reg <= step_next;
        mul_reg <= mul_next;
        if (load_out)
        begin
            o_angle_reg <= angle_reg;
            o_step_reg <= step_reg;
            o_spd_reg <= spd_reg;
            o_avg_reg <= avg_reg;
            o_dir_reg <= dir_reg;
            o_lock_reg <= lock_reg;
            o_fault_reg <= fault_reg;
        end
    end

    assign hall_in.ready = (state_reg == ST_IDLE);
    assign est_out.valid = ovalid_reg;
    assign est_out.rotor_angle = o_angle_reg;
    assign est_out.angle_step = o_step_reg;
    assign est_out.speed_raw = o_spd_reg;
    assign est_out.speed_filtered = o_avg_reg;
    assign est_out.edge_direction = o_dir_reg;
    assign est_out.locked = o_lock_reg;
    assign est_out.hall_fault = o_fault_reg;
endmodule

// File: hw/rtl/hsae_div.sv
// Restoring serial divider: one quotient bit per cycle.
module hsae_div #(
    parameter int NW = 34,
    parameter int DW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        ge = trial >= {1'b0, den_reg};
        diff = trial - {1'b0, den_reg};
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = num;
            den_next = den;
            rem_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            num_next = {num_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo = num_reg;
endmodule
